// ===== design/sps_pkg.sv =====
// Shared widths, codes and constants of the shortest path search block.
package sps_pkg;

	localparam int NODE_FW   = 5;
	localparam int WEIGHT_W  = 16;
	localparam int DIST_W    = 22;
	localparam int OUT_DIST_W = 21;
	localparam int CMD_W     = 2;
	localparam int EDGE_W    = 2 * NODE_FW + WEIGHT_W;

	localparam logic [DIST_W-1:0] DIST_INF = '1;

	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// One stored edge: source, target and weight.
	typedef struct packed {
		logic [NODE_FW-1:0]  from_node;
		logic [NODE_FW-1:0]  to_node;
		logic [WEIGHT_W-1:0] weight;
	} edge_t;

endpackage

// ===== design/sps_ram.sv =====
// Generic single-port RAM with a registered read.
module sps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ===== design/shortest_path_search.sv =====
// Shortest path search from node zero over a loaded edge table, top level.
//
//  channel   | direction | payload
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: command, from_node, to_node, weight
//  m_axis    | out       | tdata: total_distance, path_node; tuser: found;
//            |           | tlast: last
//  cfg_wr    | in        | dest_node, written when cfg_wr_en is high
//
// Clear and add items are handled in the idle state. A run item first sweeps
// the distance RAM, then does up to NODES rounds, each a scan of the distance
// RAM and a pass over the edge RAM, plus one last scan that finds nothing to
// settle. The path walk then pushes the path onto the stack RAM, and the
// output sends one item per path node.
// Reset clears the edge count, the destination, the settled flags, the state and
// the output valid; the RAM contents are left as they are. A stalled output holds the sequencer;
// the next item is taken as soon as the last result sits in the output register.
module shortest_path_search
	import sps_pkg::*;
#(
	parameter int NODES = 32,
	parameter int EDGES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // command[1:0], from_node[6:2], to_node[11:7],
	                                    // weight[27:12], zero fill above
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // total_distance[20:0], path_node[25:21],
	                                    // zero fill above
	output logic        m_axis_tuser,   // found
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic [4:0]  cfg_wr_data     // dest_node
);

	localparam int NW  = $clog2(NODES);
	localparam int EAW = (EDGES > 1) ? $clog2(EDGES) : 1;
	localparam int CW  = $clog2(EDGES + 1);
	localparam int DW  = $clog2(NODES + 1);
	localparam int NRW = NW + DIST_W;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_INIT   = 14'b00000000000010,
		ST_SCAN   = 14'b00000000000100,
		ST_SLAST  = 14'b00000000001000,
		ST_E_RD   = 14'b00000000010000,
		ST_E_CHK  = 14'b00000000100000,
		ST_E_UPD  = 14'b00000001000000,
		ST_D_RD   = 14'b00000010000000,
		ST_D_CHK  = 14'b00000100000000,
		ST_W_PUSH = 14'b00001000000000,
		ST_W_CHK  = 14'b00010000000000,
		ST_P_RD   = 14'b00100000000000,
		ST_P_OUT  = 14'b01000000000000,
		ST_NOPATH = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Input item fields.
	logic [CMD_W-1:0]    in_cmd;
	logic [NODE_FW-1:0]  in_from, in_to;
	logic [WEIGHT_W-1:0] in_weight;
	assign in_cmd    = s_axis_tdata[1:0];
	assign in_from   = s_axis_tdata[6:2];
	assign in_to     = s_axis_tdata[11:7];
	assign in_weight = s_axis_tdata[27:12];

	logic [NODE_FW-1:0] dest_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      e_q;
	logic [NODES-1:0]   settled_q;
	logic [NW-1:0]      idx_q;
	logic               rd_vld_s1;
	logic [NW-1:0]      rd_idx_s1;
	logic [DIST_W-1:0]  best_q;
	logic [NW-1:0]      best_idx_q;
	logic               have_q;
	logic [NW-1:0]      u_q;
	logic [DIST_W-1:0]  ud_q;
	logic [NW-1:0]      to_q;
	logic [WEIGHT_W-1:0] w_q;
	logic [NW-1:0]      cur_q;
	logic [DW-1:0]      depth_q;
	logic [NW-1:0]      pos_q;
	logic [OUT_DIST_W-1:0] dist_out_q;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic                  out_last_q;
	logic [OUT_DIST_W-1:0] out_dist_q;
	logic [NODE_FW-1:0]    out_node_q;

	logic in_acc, out_free, out_load;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	// A result enters the output register in this cycle.
	assign out_load      = ((state_q == ST_P_OUT) || (state_q == ST_NOPATH)) && out_free;

	// Edge RAM.
	logic          e_we;
	logic [EAW-1:0] e_addr;
	edge_t         e_wdata, e_rdata;

	assign e_we    = in_acc && (in_cmd == CMD_ADD) && (in_from != in_to) &&
	                 (32'(in_from) < NODES) && (32'(in_to) < NODES) &&
	                 (32'(count_q) < EDGES);
	assign e_addr  = (state_q == ST_IDLE) ? count_q[EAW-1:0] : e_q[EAW-1:0];
	assign e_wdata = '{from_node: in_from, to_node: in_to, weight: in_weight};

	sps_ram #(.WIDTH(EDGE_W), .DEPTH(EDGES)) u_edge_ram (
		.clk   (clk),
		.we    (e_we),
		.addr  (e_addr),
		.wdata (e_wdata),
		.rdata (e_rdata)
	);

	// Node RAM: parent in the upper bits, best distance in the lower bits.
	logic           n_we;
	logic [NW-1:0]  n_addr;
	logic [NRW-1:0] n_wdata, n_rdata;
	logic [DIST_W-1:0] n_dist;
	logic [NW-1:0]     n_parent;
	logic [DIST_W:0]   new_dist;
	logic              improve;

	assign n_dist   = n_rdata[DIST_W-1:0];
	assign n_parent = n_rdata[NRW-1:DIST_W];
	assign new_dist = {1'b0, ud_q} + (DIST_W+1)'(w_q);
	assign improve  = new_dist < {1'b0, n_dist};

	always_comb begin
		n_we    = 1'b0;
		n_addr  = idx_q;
		n_wdata = {idx_q, (idx_q == '0) ? DIST_W'(0) : DIST_INF};
		unique case (state_q)
			ST_INIT:  n_we = 1'b1;
			ST_E_CHK: n_addr = NW'(e_rdata.to_node);
			ST_E_UPD: begin
				n_addr  = to_q;
				n_we    = improve;
				n_wdata = {u_q, new_dist[DIST_W-1:0]};
			end
			ST_D_RD:  n_addr = NW'(dest_q);
			ST_W_PUSH: n_addr = cur_q;
			default:  n_addr = idx_q;
		endcase
	end

	sps_ram #(.WIDTH(NRW), .DEPTH(NODES)) u_node_ram (
		.clk   (clk),
		.we    (n_we),
		.addr  (n_addr),
		.wdata (n_wdata),
		.rdata (n_rdata)
	);

	// Path stack RAM, filled from the destination back to node zero.
	logic          s_we;
	logic [NW-1:0] s_addr, s_rdata;
	assign s_we   = (state_q == ST_W_PUSH);
	assign s_addr = s_we ? depth_q[NW-1:0] : pos_q;

	sps_ram #(.WIDTH(NW), .DEPTH(NODES)) u_stack_ram (
		.clk   (clk),
		.we    (s_we),
		.addr  (s_addr),
		.wdata (cur_q),
		.rdata (s_rdata)
	);

	// Running minimum of the scan, including the entry read last cycle.
	logic              take;
	logic [DIST_W-1:0] cand_dist;
	logic [NW-1:0]     cand_idx;
	logic              cand_have;
	assign take      = rd_vld_s1 && !settled_q[rd_idx_s1] && (n_dist < best_q);
	assign cand_dist = take ? n_dist : best_q;
	assign cand_idx  = take ? rd_idx_s1 : best_idx_q;
	assign cand_have = take || have_q;

	logic e_last;
	assign e_last = (e_q + CW'(1)) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dest_q      <= '0;
			count_q     <= '0;
			settled_q   <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				dest_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_s1 <= (state_q == ST_SCAN);
			rd_idx_s1 <= idx_q;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (in_cmd == CMD_CLEAR) begin
							count_q <= '0;
						end else if (in_cmd == CMD_ADD) begin
							if (e_we) begin
								count_q <= count_q + CW'(1);
							end
						end else if (in_cmd == CMD_RUN) begin
							settled_q <= '0;
							idx_q     <= '0;
							state_q   <= ST_INIT;
						end
					end
				end
				ST_INIT: begin
					if (idx_q == NW'(NODES - 1)) begin
						idx_q   <= '0;
						best_q  <= DIST_INF;
						have_q  <= 1'b0;
						state_q <= ST_SCAN;
					end else begin
						idx_q <= idx_q + NW'(1);
					end
				end
				ST_SCAN: begin
					// The entry read in the previous cycle joins the running minimum.
					if (rd_vld_s1) begin
						best_q     <= cand_dist;
						best_idx_q <= cand_idx;
						have_q     <= cand_have;
					end
					idx_q <= idx_q + NW'(1);
					if (idx_q == NW'(NODES - 1)) begin
						state_q <= ST_SLAST;
					end
				end
				ST_SLAST: begin
					idx_q  <= '0;
					best_q <= DIST_INF;
					have_q <= 1'b0;
					if (!cand_have) begin
						state_q <= ST_D_RD;
					end else begin
						settled_q[cand_idx] <= 1'b1;
						u_q  <= cand_idx;
						ud_q <= cand_dist;
						e_q  <= '0;
						state_q <= (count_q == '0) ? ST_SCAN : ST_E_RD;
					end
				end
				ST_E_RD: state_q <= ST_E_CHK;
				ST_E_CHK: begin
					to_q <= NW'(e_rdata.to_node);
					w_q  <= e_rdata.weight;
					if (NW'(e_rdata.from_node) == u_q) begin
						state_q <= ST_E_UPD;
					end else begin
						e_q     <= e_q + CW'(1);
						state_q <= e_last ? ST_SCAN : ST_E_RD;
					end
				end
				ST_E_UPD: begin
					e_q     <= e_q + CW'(1);
					state_q <= e_last ? ST_SCAN : ST_E_RD;
				end
				ST_D_RD: begin
					state_q <= (32'(dest_q) < NODES) ? ST_D_CHK : ST_NOPATH;
				end
				ST_D_CHK: begin
					cur_q      <= NW'(dest_q);
					depth_q    <= '0;
					dist_out_q <= n_dist[OUT_DIST_W-1:0];
					state_q    <= (n_dist == DIST_INF) ? ST_NOPATH : ST_W_PUSH;
				end
				ST_W_PUSH: begin
					depth_q <= depth_q + DW'(1);
					if (cur_q == '0 || (depth_q + DW'(1)) == DW'(NODES)) begin
						pos_q   <= depth_q[NW-1:0];
						state_q <= ST_P_RD;
					end else begin
						state_q <= ST_W_CHK;
					end
				end
				ST_W_CHK: begin
					cur_q   <= n_parent;
					state_q <= ST_W_PUSH;
				end
				ST_P_RD: state_q <= ST_P_OUT;
				ST_P_OUT: begin
					if (out_free) begin
						out_found_q <= 1'b1;
						out_dist_q  <= dist_out_q;
						out_node_q  <= NODE_FW'(s_rdata);
						out_last_q  <= (pos_q == '0);
						if (pos_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							pos_q   <= pos_q - NW'(1);
							state_q <= ST_P_RD;
						end
					end
				end
				ST_NOPATH: begin
					if (out_free) begin
						out_found_q <= 1'b0;
						out_dist_q  <= '0;
						out_node_q  <= '0;
						out_last_q  <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {6'b0, out_node_q, out_dist_q};
	assign m_axis_tuser  = out_found_q;
	assign m_axis_tlast  = out_last_q;

	// The edge count never passes the table size.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= EDGES)
		else $error("edge count beyond table size");

	// Only a settled node has its edges relaxed.
	a_relax_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_E_UPD) |-> settled_q[u_q])
		else $error("relaxing edges of an unsettled node");

	// A no-path result is a single, all-zero item.
	a_nopath_form: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tlast && m_axis_tdata == '0))
		else $error("malformed no-path result");

	// The path walk starts from a reached destination.
	a_walk_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_D_CHK && n_dist != DIST_INF) |=> (state_q == ST_W_PUSH))
		else $error("path walk did not start");

endmodule

// ===== dv/tb_shortest_path_search.sv =====
// Self-checking testbench for the shortest path search block.
module tb_shortest_path_search;
	import sps_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_NODES = 32;
	localparam int NUM_EDGES = 256;
	localparam int CYCLE_LIMIT = 3_000_000;

	// One expected path item.
	typedef struct {
		logic                  found;
		logic [OUT_DIST_W-1:0] total_distance;
		logic [NODE_FW-1:0]    path_node;
		logic                  last;
	} path_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_wr_en = 1'b0;
	logic [4:0]  cfg_wr_data = '0;

	// Shadow of the block's graph and destination register.
	edge_t              graph_edges[NUM_EDGES];
	int                 graph_edge_count = 0;
	logic [NODE_FW-1:0] dest_shadow = '0;

	path_item_t expected_path[$];
	int         fail_count = 0;
	int         cycle_count = 0;
	// Receiver and sender behavior: idling on or off, and a long receiver hold-off request.
	bit         sink_idles = 1'b1;
	int         sink_hold_cycles = 0;
	bit         src_idles = 1'b1;

	always #5 clk = ~clk;

	shortest_path_search #(.NODES(NUM_NODES), .EDGES(NUM_EDGES)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Dijkstra from node zero over the shadow graph; queues the path items.
	task automatic predict_path();
		logic [DIST_W-1:0]  node_dist[NUM_NODES];
		logic [NODE_FW-1:0] parent[NUM_NODES];
		bit                 done[NUM_NODES];
		logic [NODE_FW-1:0] route[$];
		logic [DIST_W-1:0]  best;
		logic [DIST_W-1:0]  cand;
		int                 pick;
		int                 cur;
		path_item_t         item;
		for (int i = 0; i < NUM_NODES; i++) begin
			node_dist[i] = DIST_INF;
			parent[i] = i[NODE_FW-1:0];
			done[i] = 1'b0;
		end
		node_dist[0] = '0;
		for (int r = 0; r < NUM_NODES; r++) begin
			pick = -1;
			best = DIST_INF;
			for (int i = 0; i < NUM_NODES; i++) begin
				if (!done[i] && node_dist[i] < best) begin
					best = node_dist[i];
					pick = i;
				end
			end
			if (pick < 0)
				break;
			done[pick] = 1'b1;
			// Edges relax in load order; only a strict improvement moves the parent.
			for (int e = 0; e < graph_edge_count; e++) begin
				if (graph_edges[e].from_node == pick) begin
					cand = best + graph_edges[e].weight;
					if (cand < node_dist[graph_edges[e].to_node]) begin
						node_dist[graph_edges[e].to_node] = cand;
						parent[graph_edges[e].to_node] = pick[NODE_FW-1:0];
					end
				end
			end
		end
		if (node_dist[dest_shadow] == DIST_INF) begin
			// Unreached destination gives a single no-path item.
			item = '{1'b0, '0, '0, 1'b1};
			expected_path.insert(expected_path.size(), item);
			return;
		end
		cur = dest_shadow;
		forever begin
			route.push_front(cur[NODE_FW-1:0]);
			if (cur == 0 || route.size() >= NUM_NODES)
				break;
			cur = parent[cur];
		end
		foreach (route[k]) begin
			item.found = 1'b1;
			item.total_distance = node_dist[dest_shadow][OUT_DIST_W-1:0];
			item.path_node = route[k];
			item.last = (k == route.size() - 1);
			expected_path.insert(expected_path.size(), item);
		end
	endtask

	// Sends one item and updates the shadow state once it is accepted.
	// Valid stays up afterwards so the next item can follow at once.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input int src, input int dst,
			input int wt);
		edge_t ed;
		if (src_idles) begin
			while ($urandom_range(0, 99) < 10) begin
				s_axis_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, wt[15:0], dst[4:0], src[4:0], cmd};
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_CLEAR) begin
			graph_edge_count = 0;
		end else if (cmd == CMD_ADD) begin
			// Self-loops and edges past capacity are dropped.
			if (src != dst && graph_edge_count < NUM_EDGES) begin
				ed.from_node = src[4:0];
				ed.to_node = dst[4:0];
				ed.weight = wt[15:0];
				graph_edges[graph_edge_count] = ed;
				graph_edge_count++;
			end
		end else if (cmd == CMD_RUN) begin
			predict_path();
		end
		@(negedge clk);
	endtask

	// Waits until every expected item is in, plus the block's drain time.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_path.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_dest(input int node);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= node[4:0];
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		dest_shadow = node[NODE_FW-1:0];
	endtask

	task automatic add_random_edges(input int count, input int span, input bit wide_weights);
		for (int i = 0; i < count; i++)
			send_item(CMD_ADD, $urandom_range(0, span - 1), $urandom_range(0, span - 1),
				wide_weights ? $urandom_range(0, 65535) : $urandom_range(0, 40));
	endtask

	// Directed: extremes, self-loop, no path, destination zero, unused command.
	task automatic test_directed();
		send_item(CMD_RUN, 0, 0, 0);                // destination zero, empty graph
		write_dest(31);
		send_item(CMD_RUN, 0, 0, 0);                // no path
		send_item(CMD_ADD, 5, 5, 100);              // self-loop, dropped
		send_item(CMD_ADD, 0, 31, 16'hFFFF);
		send_item(CMD_ADD, 0, 1, 0);
		send_item(CMD_ADD, 1, 31, 16'hFFFF);        // equal length, no improvement
		send_item(CMD_ADD, 1, 2, 16'hAAAA);
		send_item(CMD_ADD, 2, 31, 16'h5555);
		send_item(CMD_UNUSED, 31, 31, 16'hFFFF);    // unused command
		send_item(CMD_RUN, 31, 31, 16'hFFFF);
		send_item(CMD_ADD, 31, 0, 1);
		send_item(CMD_RUN, 0, 0, 0);
		send_item(CMD_CLEAR, 31, 31, 16'hFFFF);
		send_item(CMD_RUN, 0, 0, 0);                // cleared graph, no path
		// A long maximal-weight chain through every node.
		for (int i = 0; i < 31; i++)
			send_item(CMD_ADD, i, i + 1, 16'hFFFF);
		send_item(CMD_RUN, 0, 0, 0);
		write_dest(0);
		send_item(CMD_RUN, 0, 0, 0);
	endtask

	// Top the chain up to capacity, then push past it so later edges are dropped.
	task automatic test_table_full();
		write_dest(7);
		while (graph_edge_count < NUM_EDGES)
			add_random_edges(1, NUM_NODES, 1'b1);
		add_random_edges(4, NUM_NODES, 1'b1);
		send_item(CMD_ADD, 0, 7, 3);                // dropped: table is full
		send_item(CMD_RUN, 0, 0, 0);
		send_item(CMD_CLEAR, 0, 0, 0);
	endtask

	// Receiver holds off while the sender keeps offering runs.
	task automatic test_backpressure();
		write_dest(3);
		add_random_edges(6, 4, 1'b0);
		sink_hold_cycles = 400;
		for (int i = 0; i < 4; i++)
			send_item(CMD_RUN, 0, 0, 0);
		wait_drained();                             // sender pause
		send_item(CMD_CLEAR, 0, 0, 0);
	endtask

	// Random graphs with full or small node spans, runs, and a random destination each round.
	task automatic test_random();
		int span;
		for (int g = 0; g < 8; g++) begin
			span = (g % 4 == 0) ? NUM_NODES : $urandom_range(2, 10);
			write_dest($urandom_range(0, span - 1));
			if (g == 4) begin
				sink_idles = 1'b0;
				src_idles = 1'b0;
			end
			if (g == 6) begin
				sink_idles = 1'b1;
				src_idles = 1'b1;
			end
			add_random_edges($urandom_range(1, 5), span, g[0]);
			send_item(CMD_RUN, $urandom_range(0, 31), $urandom_range(0, 31), 0);
			if ($urandom_range(0, 3) == 0)
				send_item(CMD_UNUSED, $urandom_range(0, 31), 0, $urandom_range(0, 65535));
			send_item(CMD_RUN, 0, 0, 0);
			send_item(CMD_CLEAR, $urandom_range(0, 31), $urandom_range(0, 31),
				$urandom_range(0, 65535));
		end
	endtask

	// Receiver: random idling plus a counted hold-off stretch when requested.
	always @(negedge clk) begin
		if (sink_hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_cycles <= sink_hold_cycles - 1;
		end else begin
			m_axis_tready <= !(sink_idles && $urandom_range(0, 99) < 10);
		end
	end

	// Checks each accepted result against the oldest expectation.
	always @(posedge clk) begin
		path_item_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_path.size() == 0) begin
				$error("unexpected result: data %h", m_axis_tdata);
				fail_count++;
			end else begin
				want = expected_path.pop_front();
				if (m_axis_tuser !== want.found) begin
					$error("found: expected %0d actual %0d", want.found, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tdata[20:0] !== want.total_distance) begin
					$error("total_distance: expected %0d actual %0d",
						want.total_distance, m_axis_tdata[20:0]);
					fail_count++;
				end
				if (m_axis_tdata[25:21] !== want.path_node) begin
					$error("path_node: expected %0d actual %0d",
						want.path_node, m_axis_tdata[25:21]);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last: expected %0d actual %0d", want.last, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	// Timeout guard.
	always @(posedge clk) begin
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_table_full();
		test_backpressure();
		test_random();
		wait_drained();
		if (fail_count == 0 && expected_path.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
